// File: design/tbfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_pkg
// shared types, codes and arithmetic helpers of the three-band fir equalizer
// ----------------------------------------------------------------------------
package tbfe_pkg;

	localparam int NumTapsDef = 128;
	localparam int NumBands   = 3;
	localparam int NumGains   = 7;

	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;
	localparam logic [2:0] GAIN_RESET = 3'd3;
	localparam logic [2:0] GAIN_LAST  = 3'(NumGains - 1);

	typedef enum logic [2:0] {
		CMD_SAMPLE    = 3'd0,
		CMD_LOAD      = 3'd1,
		CMD_NEXT_BAND = 3'd2,
		CMD_GAIN_STEP = 3'd3,
		CMD_BYPASS    = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		JOB_SAMPLE,
		JOB_LOAD,
		JOB_GAIN
	} job_kind_t;

	typedef struct packed {
		logic [2:0]          command;
		logic signed [15:0]  left_sample;
		logic signed [15:0]  right_sample;
		logic [1:0]          band_sel;
		logic [6:0]          tap_index;
		logic signed [15:0]  tap_value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0]  left_out;
		logic signed [15:0]  right_out;
		logic                bypass_on;
		logic [1:0]          selected_band;
		logic [2:0]          low_gain_index;
		logic [2:0]          mid_gain_index;
		logic [2:0]          high_gain_index;
	} out_item_t;

	// one queued job for the back end, with a snapshot of the key state
	typedef struct packed {
		job_kind_t                   kind;
		logic signed [15:0]          left;
		logic signed [15:0]          right;
		logic [1:0]                  band;
		logic [6:0]                  idx;
		logic signed [15:0]          value;
		logic [2:0]                  gain_idx;
		logic                        bypass;
		logic [1:0]                  sel_band;
		logic [NumBands-1:0][2:0]    gains;
	} job_t;

	// q15 gain steps
	function automatic logic [15:0] gain_q15(input logic [2:0] idx);
		logic [15:0] g;
		case (idx)
			3'd0:    g = 16'h080A;
			3'd1:    g = 16'h100A;
			3'd2:    g = 16'h16A7;
			3'd3:    g = 16'h2000;
			3'd4:    g = 16'h2D34;
			3'd5:    g = 16'h3FD9;
			3'd6:    g = 16'h7F65;
			default: g = 16'h0000;
		endcase
		return g;
	endfunction

	// signed divide by 3, truncating toward zero, via reciprocal 2^17/3
	function automatic logic signed [15:0] div3(input logic signed [15:0] v);
		logic [15:0] mag;
		logic [31:0] p;
		logic [15:0] q;
		mag = v[15] ? 16'(-v) : 16'(v);
		p = 32'(mag) * 32'd43691;
		q = {1'b0, p[31:17]};
		return v[15] ? -$signed(q) : $signed(q);
	endfunction

endpackage

// File: design/tbfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_front
// accepts requests, keeps the key state, queues jobs for the back end
// ----------------------------------------------------------------------------
module tbfe_front #(
	parameter int NUM_TAPS = tbfe_pkg::NumTapsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  tbfe_pkg::in_item_t cmd,
	input  logic               clearing,
	output logic               job_valid,
	input  logic               job_ready,
	output tbfe_pkg::job_t     job
);
	import tbfe_pkg::*;

	logic [1:0]               band_q;
	logic [NumBands-1:0][2:0] gain_q;
	logic                     bypass_q;
	logic                     accept;
	logic [2:0]               gain_cur;
	logic [2:0]               gain_nxt;
	logic                     load_ok;

	assign cmd_ready = job_ready && !clearing;
	assign accept    = cmd_valid && cmd_ready;
	assign gain_cur  = gain_q[band_q];
	assign gain_nxt  = (gain_cur == GAIN_LAST) ? 3'd0 : gain_cur + 3'd1;
	assign load_ok   = (cmd.band_sel <= BAND_HIGH) && (32'(cmd.tap_index) < NUM_TAPS);

	always_comb begin
		job          = '0;
		job.left     = cmd.left_sample;
		job.right    = cmd.right_sample;
		job.band     = cmd.band_sel;
		job.idx      = cmd.tap_index;
		job.value    = cmd.tap_value;
		job.bypass   = bypass_q;
		job.sel_band = band_q;
		job.gains    = gain_q;
		job.kind     = JOB_SAMPLE;
		job.gain_idx = gain_nxt;
		job_valid    = 1'b0;
		unique case (cmd_e'(cmd.command))
			CMD_SAMPLE: begin
				job_valid = cmd_valid && !clearing;
			end
			CMD_LOAD: begin
				job.kind  = JOB_LOAD;
				job_valid = cmd_valid && !clearing && load_ok;
			end
			CMD_GAIN_STEP: begin
				job.kind  = JOB_GAIN;
				job.band  = band_q;
				job_valid = cmd_valid && !clearing;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q   <= BAND_LOW;
			gain_q   <= {NumBands{GAIN_RESET}};
			bypass_q <= 1'b1;
		end else if (accept) begin
			unique case (cmd_e'(cmd.command))
				CMD_NEXT_BAND: band_q <= (band_q == BAND_HIGH) ? BAND_LOW : band_q + 2'd1;
				CMD_GAIN_STEP: gain_q[band_q] <= gain_nxt;
				CMD_BYPASS:    bypass_q <= !bypass_q;
				default:       bypass_q <= bypass_q;
			endcase
		end
	end

endmodule

// File: design/tbfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_queue
// two-entry job queue between front and back end
// ----------------------------------------------------------------------------
module tbfe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tbfe_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tbfe_pkg::job_t pop_job
);
	import tbfe_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_job    = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: design/tbfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_back
// tap stores, gain scaling, tap combining and the stereo mac loop
// ----------------------------------------------------------------------------
module tbfe_back #(
	parameter int NUM_TAPS = tbfe_pkg::NumTapsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  tbfe_pkg::job_t      job,
	output logic                clearing,
	output logic                res_valid,
	input  logic                res_ready,
	output tbfe_pkg::out_item_t res
);
	import tbfe_pkg::*;

	localparam int AW   = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int AccW = 33 + AW;
	localparam logic [AW-1:0] LastIdx = AW'(NUM_TAPS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_MAC, ST_MDRAIN, ST_EMIT, ST_SCALE, ST_COMB
	} state_t;

	// stores
	logic signed [15:0] proto_mem [NumBands][NUM_TAPS];
	logic signed [15:0] band0_mem [NUM_TAPS];
	logic signed [15:0] band1_mem [NUM_TAPS];
	logic signed [15:0] band2_mem [NUM_TAPS];
	logic signed [15:0] comb_mem  [NUM_TAPS];
	logic signed [15:0] dll_mem   [NUM_TAPS];
	logic signed [15:0] dlr_mem   [NUM_TAPS];

	state_t                state_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         cmb_last_q;
	logic [1:0]            bnd_q;
	logic [15:0]           gain_q;
	job_t                  meta_q;
	logic signed [15:0]    res_l_q;
	logic signed [15:0]    res_r_q;
	logic                  res_valid_q;
	out_item_t             res_q;
	logic signed [AccW-1:0] acc_l_q;
	logic signed [AccW-1:0] acc_r_q;

	// pipeline
	logic                  mac_s1;
	logic signed [15:0]    comb_rd_s1;
	logic signed [15:0]    dll_rd_s1;
	logic signed [15:0]    dlr_rd_s1;
	logic                  mac_s2;
	logic signed [31:0]    prod_l_s2;
	logic signed [31:0]    prod_r_s2;
	logic                  sc_s1;
	logic [AW-1:0]         sc_idx_s1;
	logic signed [15:0]    pr_rd_s1;
	logic                  cb_s1;
	logic [AW-1:0]         cb_idx_s1;
	logic signed [15:0]    b0_rd_s1;
	logic signed [15:0]    b1_rd_s1;
	logic signed [15:0]    b2_rd_s1;

	logic                  pipe_busy;
	logic                  take;
	logic                  start_load;
	logic                  start_gain;
	logic                  start_filt;
	logic                  start_byp;
	logic                  mac_issue;
	logic                  sc_issue;
	logic                  cb_issue;
	logic [AW-1:0]         new_head;
	logic [AW-1:0]         load_addr;
	logic signed [32:0]    sc_prod;
	logic                  bd_we;
	logic [1:0]            bd_band;
	logic [AW-1:0]         bd_addr;
	logic signed [15:0]    bd_data;
	logic                  dl_we;
	logic [AW-1:0]         dl_addr;
	logic signed [15:0]    dl_l;
	logic signed [15:0]    dl_r;
	logic signed [15:0]    comb_val;

	function automatic logic signed [15:0] round_sat(input logic signed [AccW-1:0] a);
		logic signed [AccW-1:0] r;
		logic signed [AccW-1:0] q;
		logic                   fits;
		r = a + AccW'(16384);
		q = r >>> 15;
		fits = (&q[AccW-1:15]) || !(|q[AccW-1:15]);
		if (fits) return q[15:0];
		return q[AccW-1] ? 16'sh8000 : 16'sh7FFF;
	endfunction

	assign clearing  = (state_q == ST_CLEAR);
	assign pipe_busy = mac_s1 || mac_s2 || sc_s1 || cb_s1;
	assign job_ready = (state_q == ST_IDLE) && !pipe_busy;
	assign take      = job_valid && job_ready;
	assign start_load = take && (job.kind == JOB_LOAD);
	assign start_gain = take && (job.kind == JOB_GAIN);
	assign start_filt = take && (job.kind == JOB_SAMPLE) && !job.bypass;
	assign start_byp  = take && (job.kind == JOB_SAMPLE) && job.bypass;
	assign mac_issue = (state_q == ST_MAC);
	assign sc_issue  = (state_q == ST_SCALE);
	assign cb_issue  = (state_q == ST_COMB) && !sc_s1;
	assign new_head  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
	assign load_addr = AW'(job.idx);
	assign sc_prod   = pr_rd_s1 * $signed({1'b0, gain_q});
	assign comb_val  = div3(b0_rd_s1) + div3(b1_rd_s1) + div3(b2_rd_s1);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		bd_we   = 1'b0;
		bd_band = bnd_q;
		bd_addr = sc_idx_s1;
		bd_data = sc_prod[30:15];
		if (start_load) begin
			bd_we   = 1'b1;
			bd_band = job.band;
			bd_addr = load_addr;
			bd_data = job.value;
		end else if (sc_s1) begin
			bd_we = 1'b1;
		end
		dl_we   = clearing || start_filt;
		dl_addr = clearing ? idx_q : new_head;
		dl_l    = clearing ? 16'sd0 : job.left;
		dl_r    = clearing ? 16'sd0 : job.right;
	end

	// memories and their registered reads
	always_ff @(posedge clk) begin
		if (start_load) proto_mem[job.band][load_addr] <= job.value;
		if (bd_we) begin
			case (bd_band)
				BAND_LOW:  band0_mem[bd_addr] <= bd_data;
				BAND_MID:  band1_mem[bd_addr] <= bd_data;
				BAND_HIGH: band2_mem[bd_addr] <= bd_data;
				default:   ;
			endcase
		end
		if (cb_s1) comb_mem[cb_idx_s1] <= comb_val;
		if (dl_we) begin
			dll_mem[dl_addr] <= dl_l;
			dlr_mem[dl_addr] <= dl_r;
		end
		if (mac_issue) begin
			comb_rd_s1 <= comb_mem[idx_q];
			dll_rd_s1  <= dll_mem[ptr_q];
			dlr_rd_s1  <= dlr_mem[ptr_q];
		end
		if (sc_issue) pr_rd_s1 <= proto_mem[bnd_q][idx_q];
		if (cb_issue) begin
			b0_rd_s1 <= band0_mem[idx_q];
			b1_rd_s1 <= band1_mem[idx_q];
			b2_rd_s1 <= band2_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			ptr_q       <= '0;
			head_q      <= '0;
			cmb_last_q  <= '0;
			bnd_q       <= BAND_LOW;
			gain_q      <= '0;
			meta_q      <= '0;
			res_l_q     <= '0;
			res_r_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			mac_s1      <= 1'b0;
			mac_s2      <= 1'b0;
			prod_l_s2   <= '0;
			prod_r_s2   <= '0;
			sc_s1       <= 1'b0;
			sc_idx_s1   <= '0;
			cb_s1       <= 1'b0;
			cb_idx_s1   <= '0;
		end else begin
			mac_s1    <= mac_issue;
			mac_s2    <= mac_s1;
			prod_l_s2 <= comb_rd_s1 * dll_rd_s1;
			prod_r_s2 <= comb_rd_s1 * dlr_rd_s1;
			if (mac_s2) begin
				acc_l_q <= acc_l_q + AccW'(prod_l_s2);
				acc_r_q <= acc_r_q + AccW'(prod_r_s2);
			end
			sc_s1     <= sc_issue;
			sc_idx_s1 <= idx_q;
			cb_s1     <= cb_issue;
			cb_idx_s1 <= idx_q;
			// drop the result once taken, unless a new one is loaded below
			if (res_valid_q && res_ready && (state_q != ST_EMIT)) res_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
					if (idx_q == LastIdx) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take) meta_q <= job;
					if (start_load) begin
						idx_q      <= load_addr;
						cmb_last_q <= load_addr;
						state_q    <= ST_COMB;
					end else if (start_gain) begin
						bnd_q   <= job.band;
						gain_q  <= gain_q15(job.gain_idx);
						idx_q   <= '0;
						state_q <= ST_SCALE;
					end else if (start_filt) begin
						head_q  <= new_head;
						ptr_q   <= new_head;
						idx_q   <= '0;
						acc_l_q <= '0;
						acc_r_q <= '0;
						state_q <= ST_MAC;
					end else if (start_byp) begin
						res_l_q <= job.left;
						res_r_q <= job.right;
						state_q <= ST_EMIT;
					end
				end
				ST_MAC: begin
					ptr_q <= (ptr_q == '0) ? LastIdx : ptr_q - 1'b1;
					idx_q <= idx_q + 1'b1;
					if (idx_q == LastIdx) state_q <= ST_MDRAIN;
				end
				ST_MDRAIN: begin
					if (!mac_s1 && !mac_s2) begin
						res_l_q <= round_sat(acc_l_q);
						res_r_q <= round_sat(acc_r_q);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_valid_q || res_ready) begin
						res_q.left_out        <= res_l_q;
						res_q.right_out       <= res_r_q;
						res_q.bypass_on       <= meta_q.bypass;
						res_q.selected_band   <= meta_q.sel_band;
						res_q.low_gain_index  <= meta_q.gains[BAND_LOW];
						res_q.mid_gain_index  <= meta_q.gains[BAND_MID];
						res_q.high_gain_index <= meta_q.gains[BAND_HIGH];
						res_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				ST_SCALE: begin
					if (idx_q == LastIdx) begin
						idx_q      <= '0;
						cmb_last_q <= LastIdx;
						state_q    <= ST_COMB;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_COMB: begin
					if (cb_issue) begin
						if (idx_q == cmb_last_q) state_q <= ST_IDLE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/three_band_fir_equalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_band_fir_equalizer_core
// stereo three-band q15 fir equalizer with load, band, gain and bypass keys
// filtered sample: one shared mac pass over the combined taps drives both channels,
//   and the back end takes no new job until that pass and its result are done
// bypassed sample: skips the mac pass; tap load: combines the loaded tap only;
//   gain step: a scale pass, then a combine pass, over all taps
// reset: after arst_n rises the delay lines are swept to zero, during which
//   no request is taken
// ----------------------------------------------------------------------------
module three_band_fir_equalizer_core #(
	parameter int NUM_TAPS = tbfe_pkg::NumTapsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  tbfe_pkg::in_item_t  cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output tbfe_pkg::out_item_t res
);
	import tbfe_pkg::*;

	// front to queue
	logic push_valid;
	logic push_ready;
	job_t push_job;
	// queue to back
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;
	// back end sweeping the delay lines after reset
	logic clearing;

	// front: decodes each request, updates band, gain and bypass state,
	// and queues the work that touches the tap stores or gives a result
	tbfe_front #(
		.NUM_TAPS(NUM_TAPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.clearing  (clearing),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job       (push_job)
	);

	// short queue so requests keep flowing while the mac loop runs
	tbfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// back: tap memories, gain scaling, combining and the fir itself,
	// with an output register toward the result channel
	tbfe_back #(
		.NUM_TAPS(NUM_TAPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// File: design/tbfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_checker
// port-level checks on the result channel and the request ready of the equalizer core
// ----------------------------------------------------------------------------
module tbfe_props (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_ready,
	input logic                res_valid,
	input logic                res_ready,
	input tbfe_pkg::out_item_t res
);
	import tbfe_pkg::*;

	// a stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// selected band never leaves low, mid or high
	a_band_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.selected_band != 2'd3)
		else $error("selected band out of range");

	// gain indices stay within the seven table steps
	a_gain_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.low_gain_index != 3'd7) && (res.mid_gain_index != 3'd7)
			&& (res.high_gain_index != 3'd7))
		else $error("gain index out of range");

	// no request is taken in the cycle right after reset releases
	a_no_take_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !cmd_ready)
		else $error("request taken during delay line sweep");

endmodule

bind three_band_fir_equalizer_core tbfe_props u_tbfe_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
